// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame store checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pfd_pkg.sv -----
// ---------------------------------------------------------------------------
// pfd_pkg
// Geometry, link codes, item and result types, and byte/mask helpers
// for the paged frame store with dirty page flush.
// ---------------------------------------------------------------------------
package pfd_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int COL_W        = $clog2(PANEL_WIDTH);
  localparam int ROW_W        = $clog2(PANEL_HEIGHT);
  localparam int PAGE_W       = 3;
  localparam int CMD_LEN      = 4;
  localparam int LAST_POS     = CMD_LEN + PANEL_WIDTH;

  localparam logic [7:0] ALL_PAGES      = 8'((1 << PAGE_COUNT) - 1);
  localparam logic [7:0] COL_OFFSET_RST = 8'h02;

  // link bytes
  localparam logic [7:0] CTRL_CMD    = 8'h00;
  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CMD_COL_LO  = 8'h00;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] DATA_MARKER = 8'h40;

  // byte positions within a page's two transactions
  localparam logic [7:0] POS_CTRL   = 8'd0;
  localparam logic [7:0] POS_PAGE   = 8'd1;
  localparam logic [7:0] POS_COL_LO = 8'd2;
  localparam logic [7:0] POS_COL_HI = 8'd3;
  localparam logic [7:0] POS_MARKER = 8'(CMD_LEN);
  localparam logic [7:0] POS_LAST   = 8'(LAST_POS);

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_RECT  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_PULL  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic        pixel_on;
  } item_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  link_byte;
    logic        end_of_transaction;
    logic        flushing;
    logic [7:0]  dirty_mask;
  } result_t;

  function automatic logic [PAGE_W-1:0] page_of(input logic [ROW_W-1:0] row);
    logic [7:0] r;
    r = 8'(row);
    return r[5:3];
  endfunction

  // bits of one page byte covered by rows first..last
  function automatic logic [7:0] row_mask(input logic [PAGE_W-1:0] page,
                                          input logic [ROW_W-1:0]  first,
                                          input logic [ROW_W-1:0]  last);
    logic [2:0] lo;
    logic [2:0] hi;
    logic [7:0] f;
    logic [7:0] l;
    f  = 8'(first);
    l  = 8'(last);
    lo = (page == page_of(first)) ? f[2:0] : 3'd0;
    hi = (page == page_of(last))  ? l[2:0] : 3'd7;
    return (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
  endfunction

  function automatic logic [PAGE_W-1:0] lowest_page(input logic [7:0] m);
    logic [PAGE_W-1:0] p;
    p = '0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        p = PAGE_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                                input logic [COL_W-1:0]  col);
    return ADDR_W'(int'(page) * PANEL_WIDTH + int'(col));
  endfunction

  function automatic logic [7:0] cmd_byte(input logic [7:0]        pos,
                                          input logic [PAGE_W-1:0] page,
                                          input logic [7:0]        col_off);
    logic [7:0] b;
    case (pos)
      POS_CTRL:   b = CTRL_CMD;
      POS_PAGE:   b = CMD_PAGE | 8'(page);
      POS_COL_LO: b = CMD_COL_LO | {4'h0, col_off[3:0]};
      POS_COL_HI: b = CMD_COL_HI | {4'h0, col_off[7:4]};
      default:    b = DATA_MARKER;
    endcase
    return b;
  endfunction

endpackage

// ----- src/pfd_in_if.sv -----
// ---------------------------------------------------------------------------
// pfd_in_if
// Item channel: valid/ready handshake with draw, flush and pull fields.
// ---------------------------------------------------------------------------
interface pfd_in_if;
  logic          valid;
  logic          ready;
  pfd_pkg::kind_e kind;
  logic [7:0]    x_pos;
  logic [7:0]    y_pos;
  logic [7:0]    rect_width;
  logic [7:0]    rect_height;
  logic          pixel_on;

  modport source (output valid, kind, x_pos, y_pos, rect_width, rect_height, pixel_on,
                  input ready);
  modport sink   (input valid, kind, x_pos, y_pos, rect_width, rect_height, pixel_on,
                  output ready);
endinterface

// ----- src/pfd_out_if.sv -----
// ---------------------------------------------------------------------------
// pfd_out_if
// Result channel: valid/ready handshake with link byte and flush status.
// ---------------------------------------------------------------------------
interface pfd_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] link_byte;
  logic       end_of_transaction;
  logic       flushing;
  logic [7:0] dirty_mask;

  modport source (output valid, has_byte, link_byte, end_of_transaction, flushing,
                  dirty_mask, input ready);
  modport sink   (input valid, has_byte, link_byte, end_of_transaction, flushing,
                  dirty_mask, output ready);
endinterface

// ----- src/page_framebuffer_dirty_flush.sv -----
// ---------------------------------------------------------------------------
// page_framebuffer_dirty_flush
// Paged monochrome frame store with per-page dirty bits and flush stream.
// After reset the store is zeroed one byte per cycle, all STORE_BYTES bytes
// (1024 at 128x64), before the first item beat is taken.
// Pixel: one store read and, if the byte changes, one write. Rectangle: the
// same per touched byte. Pull: one store read. Flush start or ignored draw:
// no store access. A new item is taken only after the last one's result.
// ---------------------------------------------------------------------------
module page_framebuffer_dirty_flush (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfd_in_if.sink      in_i,
  pfd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0]                    column_offset_q;
  pfd_pkg::item_t                item;
  pfd_pkg::result_t              res;
  logic                          res_valid;
  logic                          res_free;
  logic                          ram_we;
  logic [pfd_pkg::ADDR_W-1:0]    ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [pfd_pkg::ADDR_W-1:0]    ram_raddr;
  logic [7:0]                    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_offset_q <= pfd_pkg::COL_OFFSET_RST;
    end else if (cfg_we_i) begin
      column_offset_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    item.kind        = in_i.kind;
    item.x_pos       = in_i.x_pos;
    item.y_pos       = in_i.y_pos;
    item.rect_width  = in_i.rect_width;
    item.rect_height = in_i.rect_height;
    item.pixel_on    = in_i.pixel_on;
  end

  pfd_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .item_i          (item),
    .column_offset_i (column_offset_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_free_i      (res_free),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  pfd_ram #(
    .WIDTH (8),
    .DEPTH (pfd_pkg::STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (res_free),
    .out_o       (out_o)
  );

endmodule

// ----- src/pfd_ram.sv -----
// ---------------------------------------------------------------------------
// pfd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pfd_out_reg.sv -----
// ---------------------------------------------------------------------------
// pfd_out_reg
// One-entry result register between the sequencer and the result channel.
// ---------------------------------------------------------------------------
module pfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  pfd_pkg::result_t  res_i,
  output logic              free_o,
  pfd_out_if.source         out_o
);

  logic             valid_q;
  pfd_pkg::result_t data_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i && free_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && free_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.has_byte           = data_q.has_byte;
  assign out_o.link_byte          = data_q.link_byte;
  assign out_o.end_of_transaction = data_q.end_of_transaction;
  assign out_o.flushing           = data_q.flushing;
  assign out_o.dirty_mask         = data_q.dirty_mask;

endmodule

// ----- src/pfd_seq.sv -----
// ---------------------------------------------------------------------------
// pfd_seq
// Sequencer: clears the store after reset, walks rectangle bytes with a
// read-modify-write, and steps the flush byte stream one pull at a time.
// ---------------------------------------------------------------------------
module pfd_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pfd_pkg::item_t               item_i,
  input  logic [7:0]                   column_offset_i,
  output logic                         res_valid_o,
  output pfd_pkg::result_t             res_o,
  input  logic                         res_free_i,
  output logic                         ram_we_o,
  output logic [pfd_pkg::ADDR_W-1:0]   ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic [pfd_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RECT_RD,
    S_RECT_WR,
    S_PULL_RD,
    S_DONE
  } state_e;

  localparam logic [8:0] W9 = 9'(pfd_pkg::PANEL_WIDTH);
  localparam logic [8:0] H9 = 9'(pfd_pkg::PANEL_HEIGHT);

  state_e                          state_q;
  logic [pfd_pkg::ADDR_W-1:0]      clr_q;
  logic                            busy_q;
  logic [pfd_pkg::PAGE_W-1:0]      fpage_q;
  logic [7:0]                      fpos_q;
  logic [7:0]                      dirty_q;
  logic [pfd_pkg::COL_W-1:0]       col_q;
  logic [pfd_pkg::COL_W-1:0]       col_first_q;
  logic [pfd_pkg::COL_W-1:0]       col_last_q;
  logic [pfd_pkg::PAGE_W-1:0]      rpage_q;
  logic [pfd_pkg::PAGE_W-1:0]      rpage_last_q;
  logic [pfd_pkg::ROW_W-1:0]       row_first_q;
  logic [pfd_pkg::ROW_W-1:0]       row_last_q;
  logic                            on_q;
  logic                            has_q;
  logic [7:0]                      byte_q;
  logic                            eot_q;

  // clipping of the incoming draw item
  logic [7:0] w_req;
  logic [7:0] h_req;
  logic [8:0] w_eff;
  logic [8:0] h_eff;
  logic [8:0] col_last9;
  logic [8:0] row_last9;
  logic       in_panel;
  logic       draw_go;

  // read-modify-write and flush stepping
  logic [7:0]                  mask;
  logic [7:0]                  new_byte;
  logic                        changed;
  logic [pfd_pkg::COL_W-1:0]   data_col;
  logic [7:0]                  dirty_after;
  logic                        accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    w_req = (item_i.kind == pfd_pkg::KIND_PIXEL) ? 8'd1 : item_i.rect_width;
    h_req = (item_i.kind == pfd_pkg::KIND_PIXEL) ? 8'd1 : item_i.rect_height;
    in_panel = ({1'b0, item_i.x_pos} < W9) && ({1'b0, item_i.y_pos} < H9);
    w_eff = (({1'b0, item_i.x_pos} + {1'b0, w_req}) > W9) ?
            W9 - {1'b0, item_i.x_pos} : {1'b0, w_req};
    h_eff = (({1'b0, item_i.y_pos} + {1'b0, h_req}) > H9) ?
            H9 - {1'b0, item_i.y_pos} : {1'b0, h_req};
    col_last9 = {1'b0, item_i.x_pos} + w_eff - 9'd1;
    row_last9 = {1'b0, item_i.y_pos} + h_eff - 9'd1;
    draw_go = !busy_q && in_panel && (w_eff != 9'd0) && (h_eff != 9'd0);
  end

  always_comb begin
    mask        = pfd_pkg::row_mask(rpage_q, row_first_q, row_last_q);
    new_byte    = on_q ? (ram_rdata_i | mask) : (ram_rdata_i & ~mask);
    changed     = new_byte != ram_rdata_i;
    data_col    = pfd_pkg::COL_W'(fpos_q - pfd_pkg::POS_MARKER - 8'd1);
    dirty_after = dirty_q & ~(8'd1 << fpage_q);
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = pfd_pkg::addr_of(rpage_q, col_q);
    ram_wdata_o = new_byte;
    // idle read points at the next flush data byte so a pull finds it ready
    ram_raddr_o = pfd_pkg::addr_of(fpage_q, data_col);
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = 8'h00;
      end
      S_RECT_RD: begin
        ram_raddr_o = pfd_pkg::addr_of(rpage_q, col_q);
      end
      S_RECT_WR: begin
        ram_we_o = changed;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.has_byte           = has_q;
    res_o.link_byte          = byte_q;
    res_o.end_of_transaction = eot_q;
    res_o.flushing           = busy_q;
    res_o.dirty_mask         = dirty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      busy_q  <= 1'b0;
      fpage_q <= '0;
      fpos_q  <= '0;
      dirty_q <= pfd_pkg::ALL_PAGES;
      has_q   <= 1'b0;
      byte_q  <= 8'h00;
      eot_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == pfd_pkg::ADDR_W'(pfd_pkg::STORE_BYTES - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (accept) begin
            has_q  <= 1'b0;
            byte_q <= 8'h00;
            eot_q  <= 1'b0;
            state_q <= S_DONE;
            unique case (item_i.kind)
              pfd_pkg::KIND_PIXEL, pfd_pkg::KIND_RECT: begin
                if (draw_go) begin
                  col_q        <= pfd_pkg::COL_W'(item_i.x_pos);
                  col_first_q  <= pfd_pkg::COL_W'(item_i.x_pos);
                  col_last_q   <= pfd_pkg::COL_W'(col_last9);
                  row_first_q  <= pfd_pkg::ROW_W'(item_i.y_pos);
                  row_last_q   <= pfd_pkg::ROW_W'(row_last9);
                  rpage_q      <= pfd_pkg::page_of(pfd_pkg::ROW_W'(item_i.y_pos));
                  rpage_last_q <= pfd_pkg::page_of(pfd_pkg::ROW_W'(row_last9));
                  on_q         <= item_i.pixel_on;
                  state_q      <= S_RECT_RD;
                end
              end
              pfd_pkg::KIND_FLUSH: begin
                if (!busy_q && (dirty_q != 8'h00)) begin
                  busy_q  <= 1'b1;
                  fpage_q <= pfd_pkg::lowest_page(dirty_q);
                  fpos_q  <= pfd_pkg::POS_CTRL;
                end
              end
              pfd_pkg::KIND_PULL: begin
                if (busy_q) begin
                  state_q <= S_PULL_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_RECT_RD: begin
          state_q <= S_RECT_WR;
        end

        S_RECT_WR: begin
          if (changed) begin
            dirty_q <= dirty_q | (8'd1 << rpage_q);
          end
          state_q <= S_RECT_RD;
          if (col_q == col_last_q) begin
            col_q <= col_first_q;
            if (rpage_q == rpage_last_q) begin
              state_q <= S_DONE;
            end else begin
              rpage_q <= rpage_q + 1'b1;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end

        S_PULL_RD: begin
          has_q  <= 1'b1;
          byte_q <= (fpos_q > pfd_pkg::POS_MARKER) ? ram_rdata_i :
                    pfd_pkg::cmd_byte(fpos_q, fpage_q, column_offset_i);
          eot_q  <= (fpos_q == pfd_pkg::POS_COL_HI) || (fpos_q == pfd_pkg::POS_LAST);
          if (fpos_q == pfd_pkg::POS_LAST) begin
            // page done: drop its bit and move on to the next dirty page
            dirty_q <= dirty_after;
            fpos_q  <= pfd_pkg::POS_CTRL;
            if (dirty_after != 8'h00) begin
              fpage_q <= pfd_pkg::lowest_page(dirty_after);
            end else begin
              busy_q <= 1'b0;
            end
          end else begin
            fpos_q <= fpos_q + 8'd1;
          end
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/pfd_checker.sv -----
// ---------------------------------------------------------------------------
// pfd_checker
// Port-level checks of the flush stream and the item handshake.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       has_byte_i,
  input logic [7:0] link_byte_i,
  input logic       eot_i,
  input logic       flushing_i,
  input logic [7:0] dirty_mask_i
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  `PFD_ASSERT_NOW(a_eot_has_byte, clk_i, rst_ni, out_beat && eot_i, has_byte_i, "end of transaction without a byte")
  `PFD_ASSERT_NOW(a_no_byte_zero, clk_i, rst_ni, out_beat && !has_byte_i, link_byte_i == 8'h00 && !eot_i, "non-byte result carries data")
  `PFD_ASSERT_NOW(a_last_byte_eot, clk_i, rst_ni, out_beat && has_byte_i && !flushing_i, eot_i, "flush ended off a transaction boundary")
  `PFD_ASSERT_NOW(a_dirty_range, clk_i, rst_ni, out_beat, (dirty_mask_i & ~pfd_pkg::ALL_PAGES) == 8'h00, "dirty bit beyond last page")
  `PFD_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, !in_ready_i, "item taken while previous one still in work")

endmodule

bind page_framebuffer_dirty_flush pfd_checker u_pfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .has_byte_i   (out_o.has_byte),
  .link_byte_i  (out_o.link_byte),
  .eot_i        (out_o.end_of_transaction),
  .flushing_i   (out_o.flushing),
  .dirty_mask_i (out_o.dirty_mask)
);

// ----- sim/tb_page_framebuffer_dirty_flush.sv -----
// ----------------------------------------------------------------------------
// tb_page_framebuffer_dirty_flush
// Drives draw, rectangle, flush and pull beats into the paged frame store and
// checks every result beat against a cycle-free shadow of the panel, dirty
// bits and flush stream, across several column offsets and random stalls.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_dirty_flush;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int PRINT_MAX    = 20;

  // Shadow of the panel: predicts each result beat and checks the DUT's.
  class panel_shadow;
    logic [7:0]  pixels [STORE_BYTES];
    logic [7:0]  dirty;
    bit          busy;
    logic [2:0]  page;
    logic [7:0]  pos;
    logic [7:0]  col_offset;
    result_t     expected_beats [$];
    int unsigned mismatches;
    int unsigned items_seen;
    int unsigned results_seen;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      dirty        = ALL_PAGES;
      busy         = 1'b0;
      page         = '0;
      pos          = '0;
      col_offset   = COL_OFFSET_RST;
      mismatches   = 0;
      items_seen   = 0;
      results_seen = 0;
    endfunction

    function void put_pixel(int x, int y, bit on);
      int         idx;
      logic [7:0] mask;
      if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
      idx  = (y / 8) * PANEL_WIDTH + x;
      mask = 8'h01 << (y % 8);
      if (((pixels[idx] & mask) != 0) == on) return;
      pixels[idx] = on ? (pixels[idx] | mask) : (pixels[idx] & ~mask);
      dirty[y / 8] = 1'b1;
    endfunction

    function void fill_rect(int x, int y, int w, int h, bit on);
      if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
      if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
      if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
      for (int dx = 0; dx < w; dx++)
        for (int dy = 0; dy < h; dy++)
          put_pixel(x + dx, y + dy, on);
    endfunction

    function bit seek_dirty_page();
      for (int p = 0; p < 8; p++) begin
        if (dirty[p]) begin
          page = p[2:0];
          pos  = '0;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      result_t r;
      r = '0;
      case (it.kind)
        KIND_PIXEL: begin
          if (!busy) put_pixel(it.x_pos, it.y_pos, it.pixel_on);
        end
        KIND_RECT: begin
          if (!busy) fill_rect(it.x_pos, it.y_pos, it.rect_width, it.rect_height, it.pixel_on);
        end
        KIND_FLUSH: begin
          if (!busy && seek_dirty_page()) busy = 1'b1;
        end
        KIND_PULL: begin
          if (busy) begin
            r.has_byte = 1'b1;
            case (pos)
              POS_CTRL:   r.link_byte = CTRL_CMD;
              POS_PAGE:   r.link_byte = CMD_PAGE | {5'b0, page};
              POS_COL_LO: r.link_byte = CMD_COL_LO | {4'h0, col_offset[3:0]};
              POS_COL_HI: r.link_byte = CMD_COL_HI | {4'h0, col_offset[7:4]};
              POS_MARKER: r.link_byte = DATA_MARKER;
              default: begin
                r.link_byte = pixels[int'(page) * PANEL_WIDTH + int'(pos) - int'(POS_MARKER) - 1];
              end
            endcase
            r.end_of_transaction = (pos == POS_COL_HI) || (pos >= POS_LAST);
            if (pos >= POS_LAST) begin
              dirty[page] = 1'b0;
              if (!seek_dirty_page()) begin
                busy = 1'b0;
                pos  = '0;
              end
            end else begin
              pos = pos + 8'd1;
            end
          end
        end
      endcase
      r.flushing   = busy;
      r.dirty_mask = dirty;
      expected_beats.push_back(r);
      items_seen++;
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= PRINT_MAX)
        $display("[%0t] mismatch, %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_beats.size() == 0) begin
        report("result beat with nothing pending", got.link_byte, 8'h00);
        return;
      end
      want = expected_beats.pop_front();
      if (got.has_byte !== want.has_byte)
        report("has_byte", 8'(got.has_byte), 8'(want.has_byte));
      if (got.link_byte !== want.link_byte)
        report("link_byte", got.link_byte, want.link_byte);
      if (got.end_of_transaction !== want.end_of_transaction)
        report("end_of_transaction", 8'(got.end_of_transaction), 8'(want.end_of_transaction));
      if (got.flushing !== want.flushing)
        report("flushing", 8'(got.flushing), 8'(want.flushing));
      if (got.dirty_mask !== want.dirty_mask)
        report("dirty_mask", got.dirty_mask, want.dirty_mask);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  pfd_in_if  in_if ();
  pfd_out_if out_if ();

  panel_shadow shadow;
  bit          gaps_on;
  bit          stall_pending;
  int unsigned quiet;
  int unsigned sink_gap;
  int unsigned offsets_used;

  page_framebuffer_dirty_flush DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    item_t   it;
    result_t r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        r.has_byte           = out_if.has_byte;
        r.link_byte          = out_if.link_byte;
        r.end_of_transaction = out_if.end_of_transaction;
        r.flushing           = out_if.flushing;
        r.dirty_mask         = out_if.dirty_mask;
        shadow.check_result(r);
      end
      if (in_if.valid && in_if.ready) begin
        it.kind        = in_if.kind;
        it.x_pos       = in_if.x_pos;
        it.y_pos       = in_if.y_pos;
        it.rect_width  = in_if.rect_width;
        it.rect_height = in_if.rect_height;
        it.pixel_on    = in_if.pixel_on;
        shadow.note_item(it);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: %0d cycles without a beat, %0d results pending",
               quiet, shadow.expected_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result sink: random stall bursts, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    sink_gap     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pending) begin
        stall_pending = 1'b0;
        sink_gap      = HOLD_CYCLES;
      end else if (gaps_on && sink_gap == 0 && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 10);
      end
      if (sink_gap > 0) begin
        out_if.ready = 1'b0;
        sink_gap--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic item_t mk(kind_e k, int x, int y, int w, int h, bit on);
    item_t it;
    it.kind        = k;
    it.x_pos       = x[7:0];
    it.y_pos       = y[7:0];
    it.rect_width  = w[7:0];
    it.rect_height = h[7:0];
    it.pixel_on    = on;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic offer(item_t it);
    in_if.valid       = 1'b1;
    in_if.kind        = it.kind;
    in_if.x_pos       = it.x_pos;
    in_if.y_pos       = it.y_pos;
    in_if.rect_width  = it.rect_width;
    in_if.rect_height = it.rect_height;
    in_if.pixel_on    = it.pixel_on;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    int n;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_if.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (shadow.expected_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_offset(logic [7:0] value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow.col_offset = value;
    offsets_used++;
  endtask

  // pull until the stream is done, other fields as noise
  task automatic drain_stream();
    while (shadow.busy) begin
      maybe_pause();
      offer(mk(KIND_PULL, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1)));
    end
  endtask

  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    it   = mk(KIND_PULL, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (shadow.busy) begin
      if (roll >= 88) it.kind = kind_e'($urandom_range(0, 2));
    end else if (roll < 55) begin
      it.kind = KIND_PIXEL;
    end else if (roll < 88) begin
      it.kind = KIND_RECT;
    end else if (roll < 91) begin
      it.kind = KIND_FLUSH;
    end
    if (it.kind == KIND_PIXEL || it.kind == KIND_RECT) begin
      if ($urandom_range(0, 9) != 0) it.x_pos = $urandom_range(0, PANEL_WIDTH - 1);
      if ($urandom_range(0, 9) == 0) it.y_pos = $urandom_range(0, 255);
      else if ($urandom_range(0, 9) < 6) it.y_pos = $urandom_range(0, 15);
      else it.y_pos = $urandom_range(0, PANEL_HEIGHT - 1);
    end
    if (it.kind == KIND_RECT) begin
      // mostly small boxes; the odd huge one hits the clipping edges
      if ($urandom_range(0, 39) != 0) it.rect_width = $urandom_range(0, 12);
      if ($urandom_range(0, 39) != 0) it.rect_height = $urandom_range(0, 12);
    end
    return it;
  endfunction

  initial begin
    item_t       it;
    logic [7:0]  phase_offset [4];
    int unsigned pages_sent;

    shadow            = new();
    gaps_on           = 1'b1;
    stall_pending     = 1'b0;
    quiet             = 0;
    offsets_used      = 0;
    pages_sent        = 0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 8'h00;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_PIXEL;
    in_if.x_pos       = 8'h00;
    in_if.y_pos       = 8'h00;
    in_if.rect_width  = 8'h00;
    in_if.rect_height = 8'h00;
    in_if.pixel_on    = 1'b0;
    phase_offset[0]   = 8'hFF;
    phase_offset[1]   = $urandom_range(1, 254);
    phase_offset[2]   = 8'hF0;
    phase_offset[3]   = $urandom_range(0, 255);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    write_offset(8'h00);

    // random drawing while every page is still dirty from reset; flush starts
    // are held back so the full stream comes in one piece later
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) stall_pending = 1'b1;
      maybe_pause();
      it = random_item();
      if (it.kind == KIND_FLUSH) it.kind = KIND_PULL;
      offer(it);
    end

    // directed drawing
    offer(mk(KIND_PULL, 255, 255, 255, 255, 1'b1));   // pull while idle
    offer(mk(KIND_PIXEL, 0, 0, 0, 0, 1'b1));
    offer(mk(KIND_PIXEL, 0, 0, 0, 0, 1'b1));          // no change
    offer(mk(KIND_PIXEL, 127, 63, 0, 0, 1'b1));
    offer(mk(KIND_PIXEL, 128, 0, 0, 0, 1'b1));        // off the right edge
    offer(mk(KIND_PIXEL, 0, 64, 0, 0, 1'b1));         // below the panel
    offer(mk(KIND_PIXEL, 255, 255, 0, 0, 1'b1));
    offer(mk(KIND_RECT, 10, 10, 0, 5, 1'b1));         // zero width
    offer(mk(KIND_RECT, 10, 10, 5, 0, 1'b1));         // zero height
    offer(mk(KIND_RECT, 120, 60, 255, 255, 1'b1));    // clipped both ways
    offer(mk(KIND_RECT, 200, 3, 4, 4, 1'b1));         // origin off the panel, nothing drawn
    offer(mk(KIND_RECT, 0, 0, 255, 255, 1'b0));       // clear the whole panel
    offer(mk(KIND_RECT, 3, 5, 7, 9, 1'b1));
    offer(mk(KIND_PIXEL, 4, 6, 0, 0, 1'b0));

    // every page is dirty, so this flush sends all of them
    offer(mk(KIND_FLUSH, 0, 0, 0, 0, 1'b0));
    offer(mk(KIND_PULL, 0, 0, 0, 0, 1'b0));
    offer(mk(KIND_PIXEL, 5, 5, 0, 0, 1'b1));          // ignored mid-flush
    offer(mk(KIND_RECT, 0, 0, 255, 255, 1'b1));       // ignored mid-flush
    offer(mk(KIND_FLUSH, 0, 0, 0, 0, 1'b0));          // ignored mid-flush
    // a new column offset at the start of each later page
    while (shadow.busy) begin
      if (shadow.pos == POS_CTRL) begin
        wait_idle();
        write_offset(phase_offset[pages_sent % 4]);
        pages_sent++;
      end
      maybe_pause();
      offer(mk(KIND_PULL, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1)));
    end

    offer(mk(KIND_FLUSH, 0, 0, 0, 0, 1'b0));          // nothing dirty
    offer(mk(KIND_PIXEL, 3, 5, 0, 0, 1'b1));          // already set, page stays clean
    offer(mk(KIND_PIXEL, 127, 63, 0, 0, 1'b1));
    wait_idle();

    // last part: no idling on either side
    gaps_on = 1'b0;
    offer(mk(KIND_FLUSH, 0, 0, 0, 0, 1'b0));
    drain_stream();
    wait_idle();

    repeat (20) @(negedge clk_i);
    $display("Covered %0d items and %0d result beats over %0d column offset writes.",
             shadow.items_seen, shadow.results_seen, offsets_used);
    $display("Pixels, clipped and off-panel rectangles, flushes and pulls, with stalls.");
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
